### rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, scanner modes, character class word and keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Token kind codes as they appear on the result channel
  typedef enum logic [4:0] {
    KIND_EOF      = 5'd0,
    KIND_IDENT    = 5'd1,
    KIND_NUM      = 5'd2,
    KIND_STRING   = 5'd3,
    KIND_IF       = 5'd4,
    KIND_THEN     = 5'd5,
    KIND_ELSE     = 5'd6,
    KIND_WHILE    = 5'd7,
    KIND_DO       = 5'd8,
    KIND_INT      = 5'd9,
    KIND_FLOAT    = 5'd10,
    KIND_LPAREN   = 5'd11,
    KIND_RPAREN   = 5'd12,
    KIND_LBRACKET = 5'd13,
    KIND_RBRACKET = 5'd14,
    KIND_LBRACE   = 5'd15,
    KIND_RBRACE   = 5'd16,
    KIND_PLUS     = 5'd17,
    KIND_MINUS    = 5'd18,
    KIND_STAR     = 5'd19,
    KIND_SLASH    = 5'd20,
    KIND_GT       = 5'd21,
    KIND_GE       = 5'd22,
    KIND_LT       = 5'd23,
    KIND_LE       = 5'd24,
    KIND_ASSIGN   = 5'd25,
    KIND_EQ       = 5'd26,
    KIND_SEMI     = 5'd27,
    KIND_COMMA    = 5'd28,
    KIND_NE       = 5'd29,
    KIND_ERROR    = 5'd30
  } token_kind_e;

  // Scanner modes of the back end
  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_IDENT    = 4'd1,
    MODE_NUM_INT  = 4'd2,
    MODE_NUM_DOT  = 4'd3,
    MODE_NUM_FRAC = 4'd4,
    MODE_STRING   = 4'd5,
    MODE_GT       = 4'd6,
    MODE_LT       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_BANG     = 4'd9
  } scan_mode_e;

  // Character codes with a special role
  localparam logic [7:0] ChEot        = 8'h00;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChDquote     = 8'h22;
  localparam logic [7:0] ChSquote     = 8'h27;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChUnderscore = 8'h5F;

  // Queue between front and back
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  // Keyword spellings, first character in the low byte, zero padded
  localparam logic [39:0] KwIf    = 40'h00_0000_6669;
  localparam logic [39:0] KwThen  = 40'h00_6e65_6874;
  localparam logic [39:0] KwElse  = 40'h00_6573_6c65;
  localparam logic [39:0] KwWhile = 40'h65_6c69_6877;
  localparam logic [39:0] KwDo    = 40'h00_0000_6f64;
  localparam logic [39:0] KwInt   = 40'h00_0074_6e69;
  localparam logic [39:0] KwFloat = 40'h74_616f_6c66;

  // Classified character word carried through the queue
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic        blank;
    logic        newline;
    logic        ident_start;
    logic        digit;
    logic        dot;
    logic        quote;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        bang;
    logic        punct;
    token_kind_e punct_kind;
  } char_class_t;

  // One result word
  typedef struct packed {
    token_kind_e kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [31:0] line;
  } token_t;

  // Map a single-character punctuation byte to its kind
  function automatic token_kind_e punct_kind(logic [7:0] c);
    token_kind_e k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Compare the identifier prefix against all keywords at once
  function automatic token_kind_e keyword_kind(logic [39:0] prefix, logic [2:0] len);
    token_kind_e k;
    k = KIND_IDENT;
    if (len == 3'd2 && prefix == KwIf)    k = KIND_IF;
    if (len == 3'd4 && prefix == KwThen)  k = KIND_THEN;
    if (len == 3'd4 && prefix == KwElse)  k = KIND_ELSE;
    if (len == 3'd5 && prefix == KwWhile) k = KIND_WHILE;
    if (len == 3'd2 && prefix == KwDo)    k = KIND_DO;
    if (len == 3'd3 && prefix == KwInt)   k = KIND_INT;
    if (len == 3'd5 && prefix == KwFloat) k = KIND_FLOAT;
    return k;
  endfunction

endpackage

### rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: character intake and classification
// Accepts one character word a cycle while the queue has room and pushes its class word to the queue.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           ch_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output stt_pkg::char_class_t push_data_o
);

  stt_pkg::token_kind_e pk;

  // Pass the handshake straight to the queue
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  // Classify the character
  always_comb begin
    pk = stt_pkg::punct_kind(ch_i);
    push_data_o.ch          = ch_i;
    push_data_o.eot         = (ch_i == stt_pkg::ChEot);
    push_data_o.blank       = (ch_i == stt_pkg::ChSpace) ||
                              (ch_i >= stt_pkg::ChTab && ch_i <= stt_pkg::ChCr);
    push_data_o.newline     = (ch_i == stt_pkg::ChNewline);
    push_data_o.ident_start = (ch_i >= "a" && ch_i <= "z") ||
                              (ch_i >= "A" && ch_i <= "Z") ||
                              (ch_i == stt_pkg::ChUnderscore);
    push_data_o.digit       = (ch_i >= "0" && ch_i <= "9");
    push_data_o.dot         = (ch_i == stt_pkg::ChDot);
    push_data_o.quote       = (ch_i == stt_pkg::ChDquote) || (ch_i == stt_pkg::ChSquote);
    push_data_o.gt          = (ch_i == ">");
    push_data_o.lt          = (ch_i == "<");
    push_data_o.eq          = (ch_i == "=");
    push_data_o.bang        = (ch_i == "!");
    push_data_o.punct       = (pk != stt_pkg::KIND_EOF);
    push_data_o.punct_kind  = pk;
  end

endmodule

### rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: short queue of classified characters
// Decouples the intake side from the scanner so each side stalls on its own.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  stt_pkg::char_class_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output stt_pkg::char_class_t pop_data_o
);

  localparam int PtrBits = stt_pkg::QueuePtrBits;

  stt_pkg::char_class_t mem_q [stt_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]     cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != (PtrBits+1)'(stt_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Track the fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back: token scanner and result buffer
// Steps the scanner once per character and serializes up to three tokens.
// ----------------------------------------------------------------------------
module stt_back #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  stt_pkg::char_class_t pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stt_pkg::token_t      out_token_o,
  output logic                 out_last_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  stt_pkg::char_class_t c;

  stt_pkg::scan_mode_e mode_q, mode_d, fresh_mode;
  logic [POSITION_BITS-1:0] begin_q, begin_d, pos_q, pos_d;
  logic [LENGTH_BITS-1:0]   count_q, count_d, inc1, inc2;
  logic [31:0]              line_q, line_d;
  logic [39:0]              prefix_q, prefix_d;
  logic [7:0]               quote_q, quote_d;

  logic                 fresh, fresh_begins, fresh_emit;
  stt_pkg::token_kind_e fresh_kind;
  logic                 ident_cont;

  logic                     pend_v, dot_v;
  stt_pkg::token_kind_e     pend_kind;
  logic [LENGTH_BITS-1:0]   pend_len;
  logic [2:0]               kw_len;

  stt_pkg::token_t pend_tok, dot_tok, fresh_tok;
  stt_pkg::token_t slot0, slot1, slot2;
  logic [1:0]      n_new;

  stt_pkg::token_t res_q [3];
  logic [1:0]      n_q, idx_q;
  logic            last, step;

  // Saturating length increment
  function automatic logic [LENGTH_BITS-1:0] sat_add(logic [LENGTH_BITS-1:0] v,
                                                     logic [1:0] d);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + (LENGTH_BITS+1)'(d);
    return s[LENGTH_BITS] ? LenMax : s[LENGTH_BITS-1:0];
  endfunction

  // Fit an offset to the 32-bit result field
  function automatic logic [31:0] fit_start(logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+31:0] w;
    w = {32'b0, v};
    return w[31:0];
  endfunction

  // Fit a length to the 16-bit result field
  function automatic logic [15:0] fit_len(logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  assign c          = pop_data_i;
  assign inc1       = sat_add(count_q, 2'd1);
  assign inc2       = sat_add(count_q, 2'd2);
  assign ident_cont = c.ident_start || c.digit;
  assign kw_len     = (count_q < LENGTH_BITS'(6)) ? count_q[2:0] : 3'd7;

  // Decode how the character starts a token when scanned afresh
  always_comb begin
    fresh_mode   = stt_pkg::MODE_IDLE;
    fresh_begins = 1'b0;
    fresh_emit   = 1'b0;
    fresh_kind   = stt_pkg::KIND_ERROR;
    if (c.eot) begin
      fresh_emit = 1'b1;
      fresh_kind = stt_pkg::KIND_EOF;
    end else if (c.blank) begin
      fresh_emit = 1'b0;
    end else if (c.ident_start) begin
      fresh_mode   = stt_pkg::MODE_IDENT;
      fresh_begins = 1'b1;
    end else if (c.digit) begin
      fresh_mode   = stt_pkg::MODE_NUM_INT;
      fresh_begins = 1'b1;
    end else if (c.quote) begin
      fresh_mode   = stt_pkg::MODE_STRING;
      fresh_begins = 1'b1;
    end else if (c.punct) begin
      fresh_emit = 1'b1;
      fresh_kind = c.punct_kind;
    end else if (c.gt) begin
      fresh_mode   = stt_pkg::MODE_GT;
      fresh_begins = 1'b1;
    end else if (c.lt) begin
      fresh_mode   = stt_pkg::MODE_LT;
      fresh_begins = 1'b1;
    end else if (c.eq) begin
      fresh_mode   = stt_pkg::MODE_EQ;
      fresh_begins = 1'b1;
    end else if (c.bang) begin
      fresh_mode   = stt_pkg::MODE_BANG;
      fresh_begins = 1'b1;
    end else begin
      fresh_emit = 1'b1;
    end
  end

  // Next scanner mode
  always_comb begin
    fresh  = 1'b0;
    mode_d = mode_q;
    unique case (mode_q)
      stt_pkg::MODE_IDENT: begin
        if (!ident_cont) fresh = 1'b1;
      end
      stt_pkg::MODE_NUM_INT: begin
        if (c.digit) mode_d = mode_q;
        else if (c.dot) mode_d = stt_pkg::MODE_NUM_DOT;
        else fresh = 1'b1;
      end
      stt_pkg::MODE_NUM_FRAC: begin
        if (!c.digit) fresh = 1'b1;
      end
      stt_pkg::MODE_NUM_DOT: begin
        if (c.digit) mode_d = stt_pkg::MODE_NUM_FRAC;
        else fresh = 1'b1;
      end
      stt_pkg::MODE_STRING: begin
        if (c.eot) fresh = 1'b1;
        else if (c.ch == quote_q) mode_d = stt_pkg::MODE_IDLE;
      end
      stt_pkg::MODE_GT, stt_pkg::MODE_LT, stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
        if (c.eq) mode_d = stt_pkg::MODE_IDLE;
        else fresh = 1'b1;
      end
      default: fresh = 1'b1;
    endcase
    if (fresh) mode_d = fresh_mode;
    if (c.eot) mode_d = stt_pkg::MODE_IDLE;
  end

  // Token closed by this character in the current mode
  always_comb begin
    pend_v    = 1'b0;
    dot_v     = 1'b0;
    pend_kind = stt_pkg::KIND_NUM;
    pend_len  = count_q;
    unique case (mode_q)
      stt_pkg::MODE_IDENT: begin
        pend_v    = !ident_cont;
        pend_kind = stt_pkg::keyword_kind(prefix_q, kw_len);
      end
      stt_pkg::MODE_NUM_INT: begin
        pend_v = !c.digit && !c.dot;
      end
      stt_pkg::MODE_NUM_FRAC: begin
        pend_v = !c.digit;
      end
      stt_pkg::MODE_NUM_DOT: begin
        pend_v = !c.digit;
        dot_v  = !c.digit;
      end
      stt_pkg::MODE_STRING: begin
        if (c.eot) begin
          pend_v    = 1'b1;
          pend_kind = stt_pkg::KIND_ERROR;
        end else if (c.ch == quote_q) begin
          pend_v    = 1'b1;
          pend_kind = stt_pkg::KIND_STRING;
          pend_len  = inc1;
        end
      end
      stt_pkg::MODE_GT: begin
        pend_v    = 1'b1;
        pend_kind = c.eq ? stt_pkg::KIND_GE : stt_pkg::KIND_GT;
        pend_len  = c.eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
      end
      stt_pkg::MODE_LT: begin
        pend_v    = 1'b1;
        pend_kind = c.eq ? stt_pkg::KIND_LE : stt_pkg::KIND_LT;
        pend_len  = c.eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
      end
      stt_pkg::MODE_EQ: begin
        pend_v    = 1'b1;
        pend_kind = c.eq ? stt_pkg::KIND_EQ : stt_pkg::KIND_ASSIGN;
        pend_len  = c.eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
      end
      stt_pkg::MODE_BANG: begin
        pend_v    = 1'b1;
        pend_kind = c.eq ? stt_pkg::KIND_NE : stt_pkg::KIND_ERROR;
        pend_len  = c.eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
      end
      default: pend_v = 1'b0;
    endcase
  end

  // Next counters, prefix and quote
  always_comb begin
    count_d  = count_q;
    begin_d  = begin_q;
    prefix_d = prefix_q;
    quote_d  = quote_q;
    line_d   = line_q;
    pos_d    = pos_q + 1'b1;
    case (mode_q)
      stt_pkg::MODE_IDENT: begin
        if (ident_cont) begin
          count_d = inc1;
          for (int j = 0; j < 5; j++) begin
            if (count_q == LENGTH_BITS'(j)) begin
              prefix_d[8*j +: 8] = prefix_q[8*j +: 8] | c.ch;
            end
          end
        end
      end
      stt_pkg::MODE_NUM_INT, stt_pkg::MODE_NUM_FRAC: begin
        if (c.digit) count_d = inc1;
      end
      stt_pkg::MODE_NUM_DOT: begin
        if (c.digit) count_d = inc2;
      end
      stt_pkg::MODE_STRING: begin
        if (!c.eot) count_d = inc1;
      end
      default: count_d = count_q;
    endcase
    if (fresh && fresh_begins) begin
      begin_d = pos_q;
      count_d = LENGTH_BITS'(1);
    end
    if (fresh && c.ident_start) prefix_d = {32'b0, c.ch};
    if (fresh && c.quote)       quote_d  = c.ch;
    if (fresh && c.newline)     line_d   = line_q + 1'b1;
    if (c.eot) begin
      count_d  = '0;
      begin_d  = '0;
      prefix_d = '0;
      quote_d  = '0;
      line_d   = '0;
      pos_d    = '0;
    end
  end

  // Build and pack the tokens of this step in order
  always_comb begin
    pend_tok.kind    = pend_kind;
    pend_tok.start   = fit_start(begin_q);
    pend_tok.length  = fit_len(pend_len);
    pend_tok.line    = line_q;
    dot_tok.kind     = stt_pkg::KIND_ERROR;
    dot_tok.start    = fit_start(pos_q - 1'b1);
    dot_tok.length   = 16'd1;
    dot_tok.line     = line_q;
    fresh_tok.kind   = fresh_kind;
    fresh_tok.start  = fit_start(pos_q);
    fresh_tok.length = c.eot ? 16'd0 : 16'd1;
    fresh_tok.line   = line_q;
    slot0 = pend_v ? pend_tok : fresh_tok;
    slot1 = dot_v ? dot_tok : fresh_tok;
    slot2 = fresh_tok;
    n_new = {1'b0, pend_v} + {1'b0, dot_v} + {1'b0, fresh && fresh_emit};
  end

  // Take a new character once the buffer is drained or drains now
  assign out_valid_o = (n_q != 2'd0);
  assign last        = (idx_q == n_q - 2'd1);
  assign out_last_o  = last;
  assign pop_ready_o = !out_valid_o || (out_ready_i && last);
  assign step        = pop_valid_i && pop_ready_o;

  // Select the buffered token on show
  always_comb begin
    case (idx_q)
      2'd0:    out_token_o = res_q[0];
      2'd1:    out_token_o = res_q[1];
      default: out_token_o = res_q[2];
    endcase
  end

  // Hold scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stt_pkg::MODE_IDLE;
      begin_q  <= '0;
      count_q  <= '0;
      pos_q    <= '0;
      line_q   <= '0;
      prefix_q <= '0;
      quote_q  <= '0;
    end else if (step) begin
      mode_q   <= mode_d;
      begin_q  <= begin_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      prefix_q <= prefix_d;
      quote_q  <= quote_d;
    end
  end

  // Advance the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= 2'd0;
      idx_q <= 2'd0;
    end else if (step) begin
      n_q   <= n_new;
      idx_q <= 2'd0;
    end else if (out_valid_o && out_ready_i) begin
      if (last) begin
        n_q   <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Load result words
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q[0] <= slot0;
      res_q[1] <= slot1;
      res_q[2] <= slot2;
    end
  end

endmodule

### rtl/core/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming tokenizer for source text
// Scans one character word a cycle unless stalled; emits kind, offset, length and line.
// ----------------------------------------------------------------------------
// Input channel: one character word per handshake on ch_i; a zero byte ends
// the text. Output channel: one token word per handshake, is_last_o marks the
// final token caused by one character. A character causes zero to three
// tokens; EOF follows any pending token at end of text, and then the offset
// and line counters restart at zero.
// A token caused by a character shows after the queue, which stores the
// character at the edge that takes it, and the scanner step, which writes
// the token into the result buffer; a busy scanner holds it in the queue.
// Throughput: one character per cycle while the receiver keeps up and each
// character causes at most one token; a character causing more tokens holds
// the scanner until its last token leaves the result buffer's single-word port.
// A four-word queue between intake and scanner absorbs short stalls; when the
// receiver stalls, the buffered token holds, the scanner waits and the queue
// fills, after which in_ready_o drops.
// Reset clears the scanner, queue and buffer; no token is pending after it.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [31:0] line_number_o,
  output logic        is_last_o
);

  stt_pkg::char_class_t push_data, pop_data;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  stt_pkg::token_t      tok;

  // Classify incoming characters
  stt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Buffer classified characters
  stt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Scan and emit tokens
  stt_back #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_token_o (tok),
    .out_last_o  (is_last_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign line_number_o  = tok.line;

endmodule

### rtl/core/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the tokenizer
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  ch_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_o,
  input logic [31:0] token_start_o,
  input logic [15:0] token_length_o,
  input logic [31:0] line_number_o,
  input logic        is_last_o
);

  logic in_take;
  assign in_take = in_valid_i && in_ready_o && (ch_i == stt_pkg::ChEot);

  // Hold the kind, offset and line of a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_start_o) && $stable(line_number_o))
    else $error("stalled token word changed");

  // Follow a non-final token at once with the next one of the same character
  a_group_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !is_last_o |=> out_valid_o)
    else $error("token group broken up");

  // End of text closes its group with zero length
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == stt_pkg::KIND_EOF |-> is_last_o &&
      token_length_o == 16'd0)
    else $error("EOF not final or not empty");

  // A non-EOF token that is not an error, identifier, number or string has nonzero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != stt_pkg::KIND_EOF && !in_take |->
      token_length_o != 16'd0 || token_kind_o == stt_pkg::KIND_ERROR ||
      token_kind_o == stt_pkg::KIND_IDENT || token_kind_o == stt_pkg::KIND_NUM ||
      token_kind_o == stt_pkg::KIND_STRING)
    else $error("fixed token with zero length");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .ch_i           (ch_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .token_start_o  (token_start_o),
  .token_length_o (token_length_o),
  .line_number_o  (line_number_o),
  .is_last_o      (is_last_o)
);
